// File: design/bpc_pkg.sv
// Shared types for the barometric pressure compensation block.
`timescale 1ns / 1ps
`default_nettype none
package bpc_pkg;

  // Calibration words unpacked from the configuration registers.
  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } cal_t;

  // Pre-digested sample handed from the front to the back.
  typedef struct packed {
    logic signed [17:0] ta;     // (adc_t >> 3) - (t1 << 1)
    logic signed [16:0] d;      // (adc_t >> 4) - t1
    logic [20:0]        pbase;  // 1048576 - adc_p
  } work_t;

  typedef struct packed {
    logic [31:0] temperature_centi;
    logic [23:0] pressure_pa;
    logic        pressure_valid;
  } result_t;

  localparam int unsigned WORK_W   = $bits(work_t);
  localparam int unsigned RESULT_W = $bits(result_t);

  localparam logic [2:0] REG_CAL_TEMP       = 3'd0;
  localparam logic [2:0] REG_CAL_PRESS_LOW  = 3'd1;
  localparam logic [2:0] REG_CAL_PRESS_HIGH = 3'd2;
  localparam logic [2:0] REG_CAL_PRESS_LAST = 3'd3;

  localparam logic [63:0] FINE_OFFSET = 64'd128000;
  localparam logic [20:0] P_FULL      = 21'd1048576;
  localparam logic [16:0] P_SCALE     = 17'd3125;
  localparam logic [31:0] T_ROUND     = 32'd128;
  localparam logic [16:0] T_MUL       = 17'd5;
  localparam logic [63:0] V1_BIAS     = 64'd1 << 47;

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

endpackage
`default_nettype wire

// File: design/bpc_queue.sv
// Small register FIFO used between the block's stages.
`timescale 1ns / 1ps
`default_nettype none
module bpc_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             wr_en;
  logic             rd_en;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign wr_en = push & ~full;
  assign rd_en = pop & ~empty;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: design/bpc_front.sv
// Front end: accept raw samples, pre-digest them and queue them for the back end.
`timescale 1ns / 1ps
`default_nettype none
module bpc_front #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  logic [19:0]    raw_pressure,
  input  logic [19:0]    raw_temperature,
  input  logic [15:0]    t1,
  input  logic           pop,
  output logic           empty,
  output bpc_pkg::work_t work
);
  import bpc_pkg::*;

  work_t            entry;
  logic [WORK_W-1:0] rd_bits;

  always_comb begin
    entry.ta    = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
    entry.d     = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, t1});
    entry.pbase = P_FULL - {1'b0, raw_pressure};
  end

  bpc_queue #(.WIDTH(WORK_W), .DEPTH(DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .wdata (entry),
    .pop   (pop),
    .empty (empty),
    .rdata (rd_bits)
  );

  assign work = work_t'(rd_bits);
endmodule
`default_nettype wire

// File: design/bpc_core.sv
// Back end: sequenced fixed-point compensation on one shared multiplier and a serial divider.
`timescale 1ns / 1ps
`default_nettype none
module bpc_core (
  input  logic             clk,
  input  logic             rst,
  input  bpc_pkg::cal_t    cal,
  input  logic             in_empty,
  output logic             in_pop,
  input  bpc_pkg::work_t   in_data,
  input  logic             out_full,
  output logic             out_push,
  output bpc_pkg::result_t out_data
);
  import bpc_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_T0   = 5'd1;
  localparam logic [4:0] S_T1   = 5'd2;
  localparam logic [4:0] S_T2   = 5'd3;
  localparam logic [4:0] S_T3   = 5'd4;
  localparam logic [4:0] S_SQ   = 5'd5;
  localparam logic [4:0] S_A    = 5'd6;
  localparam logic [4:0] S_B    = 5'd7;
  localparam logic [4:0] S_C    = 5'd8;
  localparam logic [4:0] S_D    = 5'd9;
  localparam logic [4:0] S_E    = 5'd10;
  localparam logic [4:0] S_F    = 5'd11;
  localparam logic [4:0] S_DIV  = 5'd12;
  localparam logic [4:0] S_NEG  = 5'd13;
  localparam logic [4:0] S_G    = 5'd14;
  localparam logic [4:0] S_H    = 5'd15;
  localparam logic [4:0] S_I    = 5'd16;
  localparam logic [4:0] S_J    = 5'd17;
  localparam logic [4:0] S_OUT  = 5'd18;

  logic [4:0]  state;
  logic [5:0]  cnt;

  work_t       wk;
  logic [31:0] lin;
  logic [31:0] sq32;
  logic [31:0] fine;
  logic [63:0] v1;
  logic [63:0] sq;
  logic [63:0] v2;
  logic [63:0] u;
  logic [63:0] den;
  logic [63:0] dq;
  logic [63:0] rem;
  logic [63:0] ub;
  logic        neg;
  logic [63:0] p;
  logic [63:0] ph;
  logic [63:0] wt;
  logic [63:0] acc;
  logic [63:0] s;
  result_t     res;

  logic [63:0]        m_a;
  logic signed [16:0] m_b;
  logic signed [80:0] m_full;
  logic [63:0]        prod;
  logic [64:0]        rem_sh;
  logic [64:0]        diff;
  logic [63:0]        num;

  assign m_full = $signed(m_a) * m_b;
  assign prod   = m_full[63:0];
  assign rem_sh = {rem, dq[63]};
  assign diff   = rem_sh - {1'b0, ub};
  assign num    = prod;

  always_comb begin
    m_a = '0;
    m_b = '0;
    unique case (state)
      S_T0: begin
        m_a = {{46{wk.ta[17]}}, wk.ta};
        m_b = {cal.t2[15], cal.t2};
      end
      S_T1: begin
        m_a = {{47{wk.d[16]}}, wk.d};
        m_b = wk.d;
      end
      S_T2: begin
        m_a = {{32{sq32[31]}}, sq32};
        m_b = {cal.t3[15], cal.t3};
      end
      S_T3: begin
        m_a = {{32{fine[31]}}, fine};
        m_b = T_MUL;
      end
      S_SQ: begin
        m_a = v1;
        m_b = {1'b0, v1[cnt[1:0]*16 +: 16]};
      end
      S_A: begin
        m_a = sq;
        m_b = {cal.p6[15], cal.p6};
      end
      S_B: begin
        m_a = v1;
        m_b = {cal.p5[15], cal.p5};
      end
      S_C: begin
        m_a = sq;
        m_b = {cal.p3[15], cal.p3};
      end
      S_D: begin
        m_a = v1;
        m_b = {cal.p2[15], cal.p2};
      end
      S_E: begin
        m_a = V1_BIAS + u;
        m_b = {1'b0, cal.p1};
      end
      S_F: begin
        m_a = ({43'd0, wk.pbase} << 31) - v2;
        m_b = P_SCALE;
      end
      S_G: begin
        m_a = 64'($signed(p) >>> 13);
        m_b = {cal.p9[15], cal.p9};
      end
      S_H: begin
        m_a = wt;
        m_b = {1'b0, ph[cnt[1:0]*16 +: 16]};
      end
      S_I: begin
        m_a = p;
        m_b = {cal.p8[15], cal.p8};
      end
      default: begin
        m_a = '0;
        m_b = '0;
      end
    endcase
  end

  assign in_pop   = (state == S_IDLE) && !in_empty;
  assign out_push = (state == S_OUT) && !out_full;
  assign out_data = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!in_empty) begin
            wk    <= in_data;
            state <= S_T0;
          end
        end
        S_T0: begin
          lin   <= 32'($signed(prod[31:0]) >>> 11);
          state <= S_T1;
        end
        S_T1: begin
          sq32  <= 32'($signed(prod[31:0]) >>> 12);
          state <= S_T2;
        end
        S_T2: begin
          fine  <= lin + 32'($signed(prod[31:0]) >>> 14);
          state <= S_T3;
        end
        S_T3: begin
          res.temperature_centi <= 32'($signed(prod[31:0] + T_ROUND) >>> 8);
          v1    <= {{32{fine[31]}}, fine} - FINE_OFFSET;
          cnt   <= '0;
          state <= S_SQ;
        end
        S_SQ: begin
          sq  <= ((cnt[1:0] == 2'd0) ? 64'd0 : sq) + (prod << {cnt[1:0], 4'd0});
          cnt <= cnt + 1'b1;
          if (cnt[1:0] == 2'd3) begin
            state <= S_A;
          end
        end
        S_A: begin
          v2    <= prod;
          state <= S_B;
        end
        S_B: begin
          v2    <= v2 + (prod << 17) + (sx16(cal.p4) << 35);
          state <= S_C;
        end
        S_C: begin
          u     <= 64'($signed(prod) >>> 8);
          state <= S_D;
        end
        S_D: begin
          u     <= u + (prod << 12);
          state <= S_E;
        end
        S_E: begin
          den   <= 64'($signed(prod) >>> 33);
          state <= S_F;
        end
        S_F: begin
          if (den == '0) begin
            res.pressure_pa    <= '0;
            res.pressure_valid <= 1'b0;
            state              <= S_OUT;
          end else begin
            dq    <= num[63] ? (64'd0 - num) : num;
            ub    <= den[63] ? (64'd0 - den) : den;
            neg   <= num[63] ^ den[63];
            rem   <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (!diff[64]) begin
            rem <= diff[63:0];
            dq  <= {dq[62:0], 1'b1};
          end else begin
            rem <= rem_sh[63:0];
            dq  <= {dq[62:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == 6'd63) begin
            state <= S_NEG;
          end
        end
        S_NEG: begin
          p     <= neg ? (64'd0 - dq) : dq;
          state <= S_G;
        end
        S_G: begin
          ph    <= 64'($signed(p) >>> 13);
          wt    <= prod;
          cnt   <= '0;
          state <= S_H;
        end
        S_H: begin
          acc <= ((cnt[1:0] == 2'd0) ? 64'd0 : acc) + (prod << {cnt[1:0], 4'd0});
          cnt <= cnt + 1'b1;
          if (cnt[1:0] == 2'd3) begin
            state <= S_I;
          end
        end
        S_I: begin
          s     <= p + 64'($signed(acc) >>> 25) + 64'($signed(prod) >>> 19);
          state <= S_J;
        end
        S_J: begin
          res.pressure_pa    <= 24'(((64'($signed(s) >>> 8)) + (sx16(cal.p7) << 4)) >> 8);
          res.pressure_valid <= 1'b1;
          state              <= S_OUT;
        end
        S_OUT: begin
          if (!out_full) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    in_pop |-> (state == S_IDLE) && !in_empty)
    else $error("sample taken while the sequencer is busy");
  a_pop_starts: assert property (@(posedge clk) disable iff (rst)
    in_pop |=> (state == S_T0))
    else $error("sequencer did not start after taking a sample");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    out_push |-> !out_full && (state == S_OUT))
    else $error("result pushed into a full queue");
  a_push_done: assert property (@(posedge clk) disable iff (rst)
    out_push |=> (state == S_IDLE))
    else $error("sequencer did not return to idle after a result");
`endif
endmodule
`default_nettype wire

// File: design/barometric_pressure_compensation_top.sv
// Top level of the barometric pressure compensation block.
// Sequencing: the back-end sequencer runs one sample at a time on a radix-2 serial
//   divider and a shared 64x17 multiplier, and takes no new sample until its result
//   is pushed; a zero divisor skips the divider.
// Reset: rst is synchronous, active high; it empties both queues, idles the sequencer
//   and clears all calibration registers to zero.
`timescale 1ns / 1ps
`default_nettype none
module barometric_pressure_compensation_top #(
  parameter int unsigned WORK_DEPTH   = 4,
  parameter int unsigned RESULT_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [19:0] raw_pressure,
  input  logic [19:0] raw_temperature,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output logic        empty,
  input  logic        pop,
  output logic signed [31:0] temperature_centi,
  output logic [23:0] pressure_pa,
  output logic        pressure_valid
);
  import bpc_pkg::*;

  // Calibration registers, each written when a configuration transaction to its index completes.
  logic [47:0] cal_temp_words;
  logic [63:0] cal_press_low_words;
  logic [63:0] cal_press_high_words;
  logic [15:0] cal_press_last_word;

  cal_t    cal;
  work_t   work;
  logic    work_empty;
  logic    work_pop;
  logic    res_full;
  logic    res_push;
  result_t res_in;
  result_t res_out;
  logic [RESULT_W-1:0] res_bits;

  // Writes never stall.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_temp_words       <= '0;
      cal_press_low_words  <= '0;
      cal_press_high_words <= '0;
      cal_press_last_word  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CAL_TEMP:       cal_temp_words       <= cfg_data[47:0];
        REG_CAL_PRESS_LOW:  cal_press_low_words  <= cfg_data;
        REG_CAL_PRESS_HIGH: cal_press_high_words <= cfg_data;
        REG_CAL_PRESS_LAST: cal_press_last_word  <= cfg_data[15:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  // Unpack the calibration words into named coefficients.
  always_comb begin
    cal.t1 = cal_temp_words[15:0];
    cal.t2 = cal_temp_words[31:16];
    cal.t3 = cal_temp_words[47:32];
    cal.p1 = cal_press_low_words[15:0];
    cal.p2 = cal_press_low_words[31:16];
    cal.p3 = cal_press_low_words[47:32];
    cal.p4 = cal_press_low_words[63:48];
    cal.p5 = cal_press_high_words[15:0];
    cal.p6 = cal_press_high_words[31:16];
    cal.p7 = cal_press_high_words[47:32];
    cal.p8 = cal_press_high_words[63:48];
    cal.p9 = cal_press_last_word;
  end

  // Front: take samples and pre-compute the offset terms into the work queue.
  bpc_front #(.DEPTH(WORK_DEPTH)) u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .raw_pressure    (raw_pressure),
    .raw_temperature (raw_temperature),
    .t1              (cal.t1),
    .pop             (work_pop),
    .empty           (work_empty),
    .work            (work)
  );

  // Back: run the compensation sequence, one sample at a time.
  bpc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cal      (cal),
    .in_empty (work_empty),
    .in_pop   (work_pop),
    .in_data  (work),
    .out_full (res_full),
    .out_push (res_push),
    .out_data (res_in)
  );

  // Result queue decouples the sequencer from a stalled consumer.
  bpc_queue #(.WIDTH(RESULT_W), .DEPTH(RESULT_DEPTH)) u_results (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .full  (res_full),
    .wdata (res_in),
    .pop   (pop),
    .empty (empty),
    .rdata (res_bits)
  );

  assign res_out           = result_t'(res_bits);
  assign temperature_centi = res_out.temperature_centi;
  assign pressure_pa       = res_out.pressure_pa;
  assign pressure_valid    = res_out.pressure_valid;
endmodule
`default_nettype wire

// File: bench/bpc_checker.sv
// Result checker for the barometric pressure compensation block.
`timescale 1ns / 1ps
module bpc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [19:0] raw_pressure,
  input  logic [19:0] raw_temperature,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        empty,
  input  logic        pop,
  input  logic [31:0] temperature_centi,
  input  logic [23:0] pressure_pa,
  input  logic        pressure_valid,
  output int          fail_count,
  output int          pending
);
  import bpc_pkg::*;

  logic [47:0] cal_temp;
  logic [63:0] cal_plo;
  logic [63:0] cal_phi;
  logic [15:0] cal_p9;
  result_t     expected_results[$];

  function automatic logic [63:0] sext(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic result_t compensate(input logic [19:0] raw_p, input logic [19:0] raw_t);
    logic [31:0] t1, t2, t3, a, lin, d, m, sq, quad, fine, temp;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] v1, v2, x, pp, num, den, q, ph, w1, w2;
    result_t r;
    t1 = {16'b0, cal_temp[15:0]};
    t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
    t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
    p1 = {48'b0, cal_plo[15:0]};
    p2 = sext(cal_plo[31:16]);
    p3 = sext(cal_plo[47:32]);
    p4 = sext(cal_plo[63:48]);
    p5 = sext(cal_phi[15:0]);
    p6 = sext(cal_phi[31:16]);
    p7 = sext(cal_phi[47:32]);
    p8 = sext(cal_phi[63:48]);
    p9 = sext(cal_p9);

    // 32-bit temperature path; keep every arithmetic shift in its own statement
    a = ({12'b0, raw_t} >> 3) - (t1 << 1);
    a = a * t2;
    lin = $signed(a) >>> 11;
    d = ({12'b0, raw_t} >> 4) - t1;
    m = d * d;
    sq = $signed(m) >>> 12;
    m = sq * t3;
    quad = $signed(m) >>> 14;
    fine = lin + quad;
    m = fine * 32'd5 + 32'd128;
    temp = $signed(m) >>> 8;

    // 64-bit pressure path
    v1 = {{32{fine[31]}}, fine} - 64'd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    x = v1 * v1 * p3;
    x = $signed(x) >>> 8;
    v1 = x + ((v1 * p2) << 12);
    x = ((64'd1 << 47) + v1) * p1;
    v1 = $signed(x) >>> 33;

    r.temperature_centi = temp;
    r.pressure_pa = '0;
    r.pressure_valid = 1'b0;
    if (v1 != 64'd0) begin
      pp = 64'd1048576 - {44'b0, raw_p};
      num = ((pp << 31) - v2) * 64'd3125;
      den = v1;
      // truncating signed divide; most negative / -1 wraps naturally
      q = (num[63] ? 64'd0 - num : num) / (den[63] ? 64'd0 - den : den);
      pp = (num[63] != den[63]) ? 64'd0 - q : q;
      ph = $signed(pp) >>> 13;
      x = p9 * ph * ph;
      w1 = $signed(x) >>> 25;
      x = p8 * pp;
      w2 = $signed(x) >>> 19;
      x = pp + w1 + w2;
      x = $signed(x) >>> 8;
      pp = x + (p7 << 4);
      r.pressure_pa = pp[31:8];
      r.pressure_valid = 1'b1;
    end
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      cal_temp <= '0;
      cal_plo <= '0;
      cal_phi <= '0;
      cal_p9 <= '0;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CAL_TEMP:       cal_temp <= cfg_data[47:0];
          REG_CAL_PRESS_LOW:  cal_plo <= cfg_data;
          REG_CAL_PRESS_HIGH: cal_phi <= cfg_data;
          REG_CAL_PRESS_LAST: cal_p9 <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (push && !full)
        expected_results.push_back(compensate(raw_pressure, raw_temperature));
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: temp %0d press %0d valid %0b",
                     $signed(temperature_centi), pressure_pa, pressure_valid);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (want.temperature_centi !== temperature_centi ||
              want.pressure_pa !== pressure_pa || want.pressure_valid !== pressure_valid) begin
            if (fail_count < 10)
              $display("result error: temp exp %0d got %0d, press exp %0d got %0d, valid exp %0b got %0b",
                       $signed(want.temperature_centi), $signed(temperature_centi),
                       want.pressure_pa, pressure_pa, want.pressure_valid, pressure_valid);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// File: bench/tb.sv
// Stimulus and verdict for the barometric pressure compensation block.
`timescale 1ns / 1ps
module tb;
  import bpc_pkg::*;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int DRAIN_CYCLES = 120;   // a bit above the block's sample-to-result latency
  localparam int PHASES       = 8;
  localparam int ITEMS_PER_PHASE = 180;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [19:0] raw_pressure;
  logic [19:0] raw_temperature;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        empty;
  logic        pop;
  logic signed [31:0] temperature_centi;
  logic [23:0] pressure_pa;
  logic        pressure_valid;
  logic        steady;        // high: neither side idles
  int          fail_count;
  int          pending;
  int          cycles;

  barometric_pressure_compensation_top i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .raw_pressure(raw_pressure), .raw_temperature(raw_temperature),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .empty(empty), .pop(pop), .temperature_centi(temperature_centi),
    .pressure_pa(pressure_pa), .pressure_valid(pressure_valid)
  );

  bpc_checker i_checker (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .raw_pressure(raw_pressure), .raw_temperature(raw_temperature),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .empty(empty), .pop(pop), .temperature_centi(temperature_centi),
    .pressure_pa(pressure_pa), .pressure_valid(pressure_valid),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("barometric_pressure_compensation_top: mismatch");
      $finish;
    end
  end

  // Receiver: pop in most cycles, stall about 7 in 100 unless in the steady stretch.
  always @(negedge clk) begin
    if (rst)
      pop <= 1'b0;
    else
      pop <= steady || ($urandom_range(0, 99) >= 7);
  end

  // Present one sample and hold it until the transaction completes.
  task automatic send_sample(input logic [19:0] rp, input logic [19:0] rt);
    bit done;
    while (!steady && $urandom_range(0, 99) < 7) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    raw_pressure = rp;
    raw_temperature = rt;
    done = 0;
    while (!done) begin
      @(posedge clk);
      done = !full;
      @(negedge clk);
    end
    push = 1'b0;
  endtask

  // Drain the block, then let the back end settle before touching registers.
  task automatic wait_idle();
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    bit done;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    done = 0;
    while (!done) begin
      @(posedge clk);
      done = cfg_ready;
      @(negedge clk);
    end
    cfg_valid = 1'b0;
  endtask

  task automatic load_cal(input logic [63:0] tw, input logic [63:0] lo,
                          input logic [63:0] hi, input logic [63:0] last);
    write_reg(REG_CAL_TEMP, tw);
    write_reg(REG_CAL_PRESS_LOW, lo);
    write_reg(REG_CAL_PRESS_HIGH, hi);
    write_reg(REG_CAL_PRESS_LAST, last);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Sweep the raw extremes, plus two mid-range samples, under the current calibration.
  task automatic directed_corners();
    send_sample(20'h00000, 20'h00000);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'h00000, 20'hFFFFF);
    send_sample(20'hFFFFF, 20'h00000);
    send_sample(20'h5A5A5, 20'hA5A5A);
    send_sample(20'd415148, 20'd519888);
  endtask

  localparam logic [63:0] TYP_T  = {16'hFC18, 16'd26435, 16'd27504};
  localparam logic [63:0] TYP_LO = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
  localparam logic [63:0] TYP_HI = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
  localparam logic [63:0] TYP_P9 = 64'd6000;

  initial begin
    logic [19:0] rp, rt;
    cycles = 0;
    steady = 1'b0;
    rst = 1'b1;
    push = 1'b0;
    raw_pressure = '0;
    raw_temperature = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pop = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset calibration is all zero: divisor is zero, pressure must come back invalid.
    directed_corners();
    wait_idle();

    // Typical factory calibration, plus writes to two unused indexes that must be dropped.
    load_cal(TYP_T, TYP_LO, TYP_HI, TYP_P9);
    write_reg(3'd5, rand64());
    write_reg(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
    directed_corners();
    wait_idle();

    // Every calibration bit set: heavy wrap in both paths.
    load_cal(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
             64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    directed_corners();
    wait_idle();

    // Most negative signed fields with P1 and T1 at their maximum.
    load_cal({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'h8000, 16'hFFFF},
             {16'h8000, 16'h8000, 16'h8000, 16'h8000}, 64'h8000);
    directed_corners();
    wait_idle();

    // Random phases: typical-ish, random, zero-P1 and P1-bit-15 calibration in turn.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: load_cal(TYP_T ^ {48'b0, 16'($urandom_range(0, 255))}, TYP_LO, TYP_HI,
                    TYP_P9 ^ 64'($urandom_range(0, 4095)));
        1: load_cal(rand64(), rand64(), rand64(), rand64());
        2: load_cal(rand64(), rand64() & 64'hFFFF_FFFF_FFFF_0000, rand64(), rand64());
        default: load_cal(rand64(), rand64() | 64'h8000, rand64(), rand64());
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Hold steady (no idling) across part of one phase.
        steady = (ph == 2 && n >= 40 && n < 160);
        // Hold off the sender once until everything has come back.
        if (ph == 1 && n == 90)
          while (pending != 0) @(negedge clk);
        if ($urandom_range(0, 3) == 0) begin
          rp = 20'($urandom_range(250000, 600000));
          rt = 20'($urandom_range(400000, 650000));
        end else begin
          rp = 20'($urandom);
          rt = 20'($urandom);
        end
        send_sample(rp, rt);
      end
      steady = 1'b0;
      wait_idle();
    end

    if (fail_count == 0)
      $display("barometric_pressure_compensation_top: match");
    else
      $display("barometric_pressure_compensation_top: mismatch");
    $finish;
  end
endmodule
